// ===== rtl/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion block: widths, constants and the
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
  localparam int ANGLE_W = 17;
  localparam int QUAT_W = 16;
  localparam int TRIG_W = 17;
  localparam int CW = 34;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN_LIMIT = 17'sd23040;
  localparam logic [32:0] HALF_RAD_Q46 = 33'd4797524517;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  function automatic cw_t atan_q30(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0: v = 32'h3243F6A8; 1: v = 32'h1DAC6705; 2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6; 4: v = 32'h03FEAB76; 5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA; 7: v = 32'h007FFF55; 8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
        18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
        21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
        default: v = 32'h0;
      endcase
      atan_q30 = cw_t'({2'b00, v});
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/euler_to_quaternion.sv =====
// Top level of the Euler-angle to quaternion converter: three CORDIC lanes,
// the merging stage and the valid pipeline. Depends on e2q_pkg, e2q_lane, e2q_merge.
//
// Usage: one transaction on the in_ channel carries roll, pitch and yaw in
// units of 1/128 degree; one transaction on the out_ channel returns the
// Q1.14 quaternion x, y, z, w. No configuration and no state between items.
// The path from acceptance to out_tvalid runs through the pipelined CORDIC in each
// lane and the product stages. Throughput is one item per cycle while the receiver
// keeps up. The whole pipeline advances only when the output register is empty or
// being read, so a stalled receiver holds every stage and drops in_tready; nothing
// is lost. Reset empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,  // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata  // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;
  localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int LAT = N + 6;

  logic en;
  logic [LAT-1:0] vld_r;
  trig_t s [3];
  trig_t c [3];
  logic signed [QUAT_W-1:0] qx, qy, qz, qw;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    e2q_lane #(.STEPS(CORDIC_STEPS)) u_lane (
      .clk(clk), .en(en),
      .angle(in_tdata[k*ANGLE_W +: ANGLE_W]),
      .sin_q15(s[k]), .cos_q15(c[k])
    );
  end

  e2q_merge u_merge (
    .clk(clk), .en(en),
    .sr(s[0]), .cr(c[0]), .sp(s[1]), .cp(c[1]), .sy(s[2]), .cy(c[2]),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw)
  );

  assign out_tdata = {qw, qz, qy, qx};
endmodule
`default_nettype wire

// ===== rtl/e2q_lane.sv =====
// One sine/cosine lane: saturation, range fold, radian scaling and a fully
// pipelined CORDIC. Depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_lane #(
  parameter int STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output logic signed [e2q_pkg::TRIG_W-1:0]  sin_q15,
  output logic signed [e2q_pkg::TRIG_W-1:0]  cos_q15
);
  import e2q_pkg::*;
  localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

  logic signed [ANGLE_W-1:0] sat, fold;
  logic flip_c;
  logic [15:0] mag_a;
  logic [15:0] mag_r;
  logic neg_r, flip0_r;
  logic [48:0] prod;
  cw_t z0;
  cw_t x_r [N+1];
  cw_t y_r [N+1];
  cw_t z_r [N+1];
  logic flip_r [N+1];

  always_comb begin
    if (angle > ANGLE_LIMIT) sat = ANGLE_LIMIT;
    else if (angle < -ANGLE_LIMIT) sat = -ANGLE_LIMIT;
    else sat = angle;
    flip_c = 1'b0;
    fold = sat;
    if (sat > HALF_TURN_LIMIT) begin
      fold = sat - ANGLE_LIMIT;
      flip_c = 1'b1;
    end else if (sat < -HALF_TURN_LIMIT) begin
      fold = sat + ANGLE_LIMIT;
      flip_c = 1'b1;
    end
    mag_a = fold[ANGLE_W-1] ? 16'(-fold) : 16'(fold);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_a;
      neg_r <= fold[ANGLE_W-1];
      flip0_r <= flip_c;
    end
  end

  assign prod = {33'd0, mag_r} * {16'd0, HALF_RAD_Q46} + 49'd32768;
  always_comb begin
    z0 = cw_t'({1'b0, prod[48:16]});
    if (neg_r) z0 = -z0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= z0;
      flip_r[0] <= flip0_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  function automatic trig_t rnd(input cw_t v, input logic f);
    cw_t t;
    trig_t r;
    begin
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd32768) r = 17'sd32768;
      else if (t < -34'sd32768) r = -17'sd32768;
      else r = trig_t'(t);
      rnd = f ? -r : r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q15 <= rnd(y_r[N], flip_r[N]);
      cos_q15 <= rnd(x_r[N], flip_r[N]);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/e2q_merge.sv =====
// Merging stage: the ZYX triple products and Q14 rounding of the four
// quaternion components. Depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_merge (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [e2q_pkg::TRIG_W-1:0] sr, cr, sp, cp, sy, cy,
  output logic signed [e2q_pkg::QUAT_W-1:0] qx, qy, qz, qw
);
  import e2q_pkg::*;
  logic signed [33:0] srcp_r, crsp_r, crcp_r, srsp_r;
  logic signed [TRIG_W-1:0] sy_r, cy_r;
  logic signed [50:0] p_r [8];

  always_ff @(posedge clk) begin
    if (en) begin
      srcp_r <= sr * cp; crsp_r <= cr * sp;
      crcp_r <= cr * cp; srsp_r <= sr * sp;
      sy_r <= sy; cy_r <= cy;
      p_r[0] <= srcp_r * cy_r; p_r[1] <= crsp_r * sy_r;
      p_r[2] <= crsp_r * cy_r; p_r[3] <= srcp_r * sy_r;
      p_r[4] <= crcp_r * sy_r; p_r[5] <= srsp_r * cy_r;
      p_r[6] <= crcp_r * cy_r; p_r[7] <= srsp_r * sy_r;
    end
  end

  function automatic logic signed [QUAT_W-1:0] q14(input logic signed [51:0] v);
    logic signed [51:0] t;
    begin
      t = (v + 52'sd1073741824) >>> 31;
      if (t > 52'sd16384) q14 = 16'sd16384;
      else if (t < -52'sd16384) q14 = -16'sd16384;
      else q14 = t[QUAT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= q14(52'(p_r[0]) - 52'(p_r[1]));
      qy <= q14(52'(p_r[2]) + 52'(p_r[3]));
      qz <= q14(52'(p_r[4]) - 52'(p_r[5]));
      qw <= q14(52'(p_r[6]) + 52'(p_r[7]));
    end
  end
endmodule
`default_nettype wire

// ===== rtl/e2q_checker.sv =====
// Port-level checker for euler_to_quaternion, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module e2q_checker (
  input wire logic clk, rst_n, in_tready, out_tvalid, out_tready,
  input wire logic [63:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("ready under stall");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready while empty");
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[63:48]) <= 16'sd16384 &&
      $signed(out_tdata[63:48]) >= -16'sd16384) else $error("range");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule
bind euler_to_quaternion e2q_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
